@@ rtl/bsc_pkg.sv @@
// Shared types, constants and microcode ROM for the bytecode stack calculator.
package bsc_pkg;

  localparam int unsigned DEF_STACK_DEPTH   = 256;
  localparam int unsigned DEF_FRACTION_BITS = 16;
  localparam int unsigned WORD_W            = 32;
  localparam int unsigned MODE_W            = 3;
  localparam int unsigned DEPTH_OUT_W       = 9;
  localparam int unsigned UPC_W             = 5;

  localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_CONST = 3'd0,
    MODE_NEG   = 3'd1,
    MODE_ADD   = 3'd2,
    MODE_SUB   = 3'd3,
    MODE_MUL   = 3'd4,
    MODE_DIV   = 3'd5,
    MODE_RET   = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_DIV0  = 2'd3
  } err_t;

  typedef enum logic {RD_TOP, RD_NEXT} rd_sel_t;
  typedef enum logic [1:0] {WR_PUSH, WR_TOP, WR_NEXT} wr_sel_t;
  typedef enum logic {WD_CONST, WD_RES} wd_sel_t;
  typedef enum logic [1:0] {SP_HOLD, SP_INC, SP_DEC} sp_op_t;
  typedef enum logic [2:0] {VAL_ZERO, VAL_CONST, VAL_B, VAL_TOPB, VAL_RES} val_sel_t;
  typedef enum logic [2:0] {
    JC_NEVER, JC_ALWAYS, JC_EMPTY, JC_LT2, JC_FULL, JC_DIVZ, JC_BUSY
  } jcond_t;

  typedef struct packed {
    logic     fetch;
    rd_sel_t  rd;
    logic     ld_a;
    logic     ld_b;
    logic     alu_go;
    logic     wr;
    wr_sel_t  wsel;
    wd_sel_t  wdat;
    sp_op_t   sp_op;
    logic     emit;
    val_sel_t val;
    err_t     err;
    logic     ret;
    jcond_t   jc;
    upc_t     target;
  } cw_t;

  typedef struct packed {
    logic empty;
    logic lt2;
    logic full;
    logic divz;
    logic alu_busy;
  } cond_t;

  localparam upc_t U_IDLE      = 5'd0;
  localparam upc_t U_PUSH_CHK  = 5'd1;
  localparam upc_t U_PUSH_WR   = 5'd2;
  localparam upc_t U_OVF_RD    = 5'd3;
  localparam upc_t U_OVF_LD    = 5'd4;
  localparam upc_t U_OVF_EMIT  = 5'd5;
  localparam upc_t U_NEG_CHK   = 5'd6;
  localparam upc_t U_NEG_RD    = 5'd7;
  localparam upc_t U_NEG_LD    = 5'd8;
  localparam upc_t U_NEG_GO    = 5'd9;
  localparam upc_t U_NEG_WAIT  = 5'd10;
  localparam upc_t U_NEG_WB    = 5'd11;
  localparam upc_t U_BIN_CHK   = 5'd12;
  localparam upc_t U_BIN_RDB   = 5'd13;
  localparam upc_t U_BIN_LDB   = 5'd14;
  localparam upc_t U_BIN_LDA   = 5'd15;
  localparam upc_t U_BIN_GO    = 5'd16;
  localparam upc_t U_BIN_WAIT  = 5'd17;
  localparam upc_t U_BIN_WB    = 5'd18;
  localparam upc_t U_RET_CHK   = 5'd19;
  localparam upc_t U_RET_RD    = 5'd20;
  localparam upc_t U_RET_LD    = 5'd21;
  localparam upc_t U_RET_EMIT  = 5'd22;
  localparam upc_t U_UND_EMPTY = 5'd23;
  localparam upc_t U_UND_RET   = 5'd24;
  localparam upc_t U_UND_RD    = 5'd25;
  localparam upc_t U_UND_LD    = 5'd26;
  localparam upc_t U_UND_EMIT  = 5'd27;
  localparam upc_t U_DIV0_EMIT = 5'd28;
  localparam upc_t U_NOP_RD    = 5'd29;
  localparam upc_t U_NOP_LD    = 5'd30;
  localparam upc_t U_NOP_EMIT  = 5'd31;

  function automatic logic [WORD_W-1:0] sat33(logic [WORD_W:0] s);
    logic [WORD_W-1:0] r;
    if (s[WORD_W] != s[WORD_W-1]) begin
      r = s[WORD_W] ? WORD_MIN : WORD_MAX;
    end else begin
      r = s[WORD_W-1:0];
    end
    return r;
  endfunction

  function automatic cw_t cw_idle();
    cw_t c;
    c.fetch  = 1'b0;
    c.rd     = RD_TOP;
    c.ld_a   = 1'b0;
    c.ld_b   = 1'b0;
    c.alu_go = 1'b0;
    c.wr     = 1'b0;
    c.wsel   = WR_PUSH;
    c.wdat   = WD_CONST;
    c.sp_op  = SP_HOLD;
    c.emit   = 1'b0;
    c.val    = VAL_ZERO;
    c.err    = ERR_OK;
    c.ret    = 1'b0;
    c.jc     = JC_NEVER;
    c.target = U_IDLE;
    return c;
  endfunction

  function automatic cw_t ucode(upc_t addr);
    cw_t c;
    c = cw_idle();
    unique case (addr)
      U_IDLE:      c.fetch = 1'b1;
      U_PUSH_CHK:  begin c.jc = JC_FULL; c.target = U_OVF_RD; end
      U_PUSH_WR:   begin
        c.wr = 1'b1; c.wsel = WR_PUSH; c.wdat = WD_CONST; c.sp_op = SP_INC;
        c.emit = 1'b1; c.val = VAL_CONST; c.jc = JC_ALWAYS;
      end
      U_OVF_RD:    ;
      U_OVF_LD:    c.ld_b = 1'b1;
      U_OVF_EMIT:  begin c.emit = 1'b1; c.val = VAL_B; c.err = ERR_OVER; c.jc = JC_ALWAYS; end
      U_NEG_CHK:   begin c.jc = JC_EMPTY; c.target = U_UND_EMPTY; end
      U_NEG_RD:    ;
      U_NEG_LD:    c.ld_b = 1'b1;
      U_NEG_GO:    c.alu_go = 1'b1;
      U_NEG_WAIT:  begin c.jc = JC_BUSY; c.target = U_NEG_WAIT; end
      U_NEG_WB:    begin
        c.wr = 1'b1; c.wsel = WR_TOP; c.wdat = WD_RES;
        c.emit = 1'b1; c.val = VAL_RES; c.jc = JC_ALWAYS;
      end
      U_BIN_CHK:   begin c.jc = JC_LT2; c.target = U_UND_RD; end
      U_BIN_RDB:   ;
      U_BIN_LDB:   begin c.ld_b = 1'b1; c.rd = RD_NEXT; end
      U_BIN_LDA:   begin c.ld_a = 1'b1; c.jc = JC_DIVZ; c.target = U_DIV0_EMIT; end
      U_BIN_GO:    c.alu_go = 1'b1;
      U_BIN_WAIT:  begin c.jc = JC_BUSY; c.target = U_BIN_WAIT; end
      U_BIN_WB:    begin
        c.wr = 1'b1; c.wsel = WR_NEXT; c.wdat = WD_RES; c.sp_op = SP_DEC;
        c.emit = 1'b1; c.val = VAL_RES; c.jc = JC_ALWAYS;
      end
      U_RET_CHK:   begin c.jc = JC_EMPTY; c.target = U_UND_RET; end
      U_RET_RD:    ;
      U_RET_LD:    c.ld_b = 1'b1;
      U_RET_EMIT:  begin
        c.sp_op = SP_DEC; c.emit = 1'b1; c.val = VAL_B; c.ret = 1'b1; c.jc = JC_ALWAYS;
      end
      U_UND_EMPTY: begin c.emit = 1'b1; c.val = VAL_ZERO; c.err = ERR_UNDER; c.jc = JC_ALWAYS; end
      U_UND_RET:   begin
        c.emit = 1'b1; c.val = VAL_ZERO; c.err = ERR_UNDER; c.ret = 1'b1; c.jc = JC_ALWAYS;
      end
      U_UND_RD:    ;
      U_UND_LD:    c.ld_b = 1'b1;
      U_UND_EMIT:  begin c.emit = 1'b1; c.val = VAL_TOPB; c.err = ERR_UNDER; c.jc = JC_ALWAYS; end
      U_DIV0_EMIT: begin c.emit = 1'b1; c.val = VAL_B; c.err = ERR_DIV0; c.jc = JC_ALWAYS; end
      U_NOP_RD:    ;
      U_NOP_LD:    c.ld_b = 1'b1;
      U_NOP_EMIT:  begin c.emit = 1'b1; c.val = VAL_TOPB; c.jc = JC_ALWAYS; end
      default:     c.fetch = 1'b1;
    endcase
    return c;
  endfunction

  function automatic upc_t entry(logic [MODE_W-1:0] m);
    upc_t u;
    unique case (m) inside
      MODE_CONST:                           u = U_PUSH_CHK;
      MODE_NEG:                             u = U_NEG_CHK;
      MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: u = U_BIN_CHK;
      MODE_RET:                             u = U_RET_CHK;
      default:                              u = U_NOP_RD;
    endcase
    return u;
  endfunction

endpackage

@@ rtl/bsc_in_if.sv @@
// Instruction channel: valid/ready handshake carrying one bytecode instruction.
interface bsc_in_if import bsc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [WORD_W-1:0] constant_value;

  modport source (output valid, output mode, output constant_value, input ready);
  modport sink (input valid, input mode, input constant_value, output ready);
endinterface

@@ rtl/bsc_out_if.sv @@
// Result channel: valid/ready handshake carrying one instruction result.
interface bsc_out_if import bsc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] top_value;
  logic                     returned;
  logic [1:0]               error_code;
  logic [DEPTH_OUT_W-1:0]   stack_depth;

  modport source (output valid, output top_value, output returned, output error_code,
                  output stack_depth, input ready);
  modport sink (input valid, input top_value, input returned, input error_code,
                input stack_depth, output ready);
endinterface

@@ rtl/bsc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bsc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bsc_alu.sv @@
// Multi-cycle Q-format arithmetic unit: negate, add, subtract, multiply, divide.
module bsc_alu import bsc_pkg::*; #(
  parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mode_t             op,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic              busy,
  output logic [WORD_W-1:0] result
);

  localparam int unsigned DW    = WORD_W + FRACTION_BITS;
  localparam int unsigned CNT_W = $clog2(DW + 1);
  localparam logic [DW-1:0] QLIM_POS = DW'(64'h7FFF_FFFF);
  localparam logic [DW-1:0] QLIM_NEG = DW'(64'h8000_0000);

  mode_t                      op_r;
  logic signed [WORD_W-1:0]   opa;
  logic signed [WORD_W-1:0]   opb;
  logic                       mul_phase;
  logic signed [2*WORD_W-1:0] prod;
  logic [WORD_W:0]            rem;
  logic [DW-1:0]              quo;
  logic [WORD_W-1:0]          dvs;
  logic                       neg;
  logic [CNT_W-1:0]           cnt;

  logic [WORD_W:0]            sum;
  logic [WORD_W-1:0]          sum_sat;
  logic signed [2*WORD_W-1:0] prod_sh;
  logic [WORD_W-1:0]          mul_sat;
  logic [WORD_W:0]            rem_sh;
  logic [WORD_W:0]            rem_sub;
  logic                       rem_ge;
  logic [DW-1:0]              quo_neg;
  logic [WORD_W-1:0]          quo_sat;
  logic [WORD_W-1:0]          abs_a;
  logic [WORD_W-1:0]          abs_b;

  always_comb begin
    case (op_r)
      MODE_ADD: sum = {opa[WORD_W-1], opa} + {opb[WORD_W-1], opb};
      MODE_SUB: sum = {opa[WORD_W-1], opa} - {opb[WORD_W-1], opb};
      default:  sum = '0 - {opb[WORD_W-1], opb};
    endcase
    sum_sat = sat33(sum);

    prod_sh = prod >>> FRACTION_BITS;
    if ((&prod_sh[2*WORD_W-1:WORD_W-1]) || !(|prod_sh[2*WORD_W-1:WORD_W-1])) begin
      mul_sat = prod_sh[WORD_W-1:0];
    end else begin
      mul_sat = prod_sh[2*WORD_W-1] ? WORD_MIN : WORD_MAX;
    end

    rem_sh  = {rem[WORD_W-1:0], quo[DW-1]};
    rem_sub = rem_sh - {1'b0, dvs};
    rem_ge  = rem_sh >= {1'b0, dvs};
    quo_neg = ~quo + DW'(1);
    if (neg) begin
      quo_sat = (quo > QLIM_NEG) ? WORD_MIN : quo_neg[WORD_W-1:0];
    end else begin
      quo_sat = (quo > QLIM_POS) ? WORD_MAX : quo[WORD_W-1:0];
    end

    abs_a = a[WORD_W-1] ? (~a + WORD_W'(1)) : a;
    abs_b = b[WORD_W-1] ? (~b + WORD_W'(1)) : b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy) begin
      unique case (op_r)
        MODE_MUL: if (mul_phase) busy <= 1'b0;
        MODE_DIV: if (cnt == '0) busy <= 1'b0;
        default:  busy <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r      <= op;
      opa       <= a;
      opb       <= b;
      mul_phase <= 1'b0;
      rem       <= '0;
      quo       <= DW'(abs_a) << FRACTION_BITS;
      dvs       <= abs_b;
      neg       <= a[WORD_W-1] ^ b[WORD_W-1];
      cnt       <= CNT_W'(DW);
    end else if (busy) begin
      unique case (op_r)
        MODE_MUL: begin
          if (!mul_phase) begin
            prod      <= (2*WORD_W)'(opa) * (2*WORD_W)'(opb);
            mul_phase <= 1'b1;
          end else begin
            result <= mul_sat;
          end
        end
        MODE_DIV: begin
          if (cnt != '0) begin
            rem <= rem_ge ? rem_sub : rem_sh;
            quo <= {quo[DW-2:0], rem_ge};
            cnt <= cnt - CNT_W'(1);
          end else begin
            result <= quo_sat;
          end
        end
        default: result <= sum_sat;
      endcase
    end
  end

endmodule

@@ rtl/bsc_sequencer.sv @@
// Microprogram sequencer: step counter, control ROM and conditional jumps.
module bsc_sequencer import bsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [MODE_W-1:0] in_mode,
  input  logic              out_stall,
  input  cond_t             cond,
  output logic              in_ready,
  output cw_t               cw,
  output logic              step_en
);

  upc_t upc;
  upc_t upc_next;
  logic jump;

  always_comb begin
    cw       = ucode(upc);
    in_ready = cw.fetch;
    step_en  = !cw.fetch && !(cw.emit && out_stall);

    unique case (cw.jc)
      JC_NEVER:  jump = 1'b0;
      JC_ALWAYS: jump = 1'b1;
      JC_EMPTY:  jump = cond.empty;
      JC_LT2:    jump = cond.lt2;
      JC_FULL:   jump = cond.full;
      JC_DIVZ:   jump = cond.divz;
      JC_BUSY:   jump = cond.alu_busy;
      default:   jump = 1'b0;
    endcase

    if (cw.fetch) begin
      upc_next = in_valid ? entry(in_mode) : upc;
    end else if (!step_en) begin
      upc_next = upc;
    end else if (jump) begin
      upc_next = cw.target;
    end else begin
      upc_next = upc + UPC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

@@ rtl/bytecode_stack_calculator.sv @@
// Stack-machine bytecode calculator on signed fixed-point values (top level).
//
// Instructions enter on the instr channel (mode, constant_value) and each
// produces exactly one beat on the result channel (top_value, returned,
// error_code, stack_depth). Both channels use valid/ready; a beat moves
// when both are high. One instruction is worked at a time by the microcode
// sequencer; instr.ready is high while the sequencer waits at its idle step.
// The time from accept to the next accept is set by the microprogram length
// and the arithmetic unit; the divider works one quotient bit per cycle.
// The result shows in the output register in the same cycle that the block
// is ready again.
// If the receiver stalls, the finished beat holds in the output register and
// the next instruction is still accepted; that instruction waits at its own
// result step until the register frees up, with no stack change before then.
// Reset empties the stack and drops any pending beat; stack memory contents
// are not cleared, and data read from above the stack pointer is never used.
module bytecode_stack_calculator import bsc_pkg::*; #(
  parameter int unsigned STACK_DEPTH   = DEF_STACK_DEPTH,
  parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
  input logic      clk,
  input logic      rst,
  bsc_in_if.sink   instr,
  bsc_out_if.source result
);

  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

  cw_t               cw;
  cond_t             cond;
  logic              step_en;
  logic              out_stall;
  logic              accept;

  logic [SPW-1:0]    sp;
  logic [SPW-1:0]    sp_next;
  logic [SPW-1:0]    sp_m1;
  logic [SPW-1:0]    sp_m2;
  mode_t             mode_r;
  logic [WORD_W-1:0] cval;
  logic [WORD_W-1:0] opnd_a;
  logic [WORD_W-1:0] opnd_b;

  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] rd_data;
  logic              alu_busy;
  logic [WORD_W-1:0] alu_res;
  logic [WORD_W-1:0] val;

  logic                   out_valid;
  logic [WORD_W-1:0]      out_value;
  logic                   out_returned;
  err_t                   out_err;
  logic [DEPTH_OUT_W-1:0] out_depth;

  assign accept    = instr.valid && instr.ready;
  assign out_stall = out_valid && !result.ready;

  bsc_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (instr.valid),
    .in_mode   (instr.mode),
    .out_stall (out_stall),
    .cond      (cond),
    .in_ready  (instr.ready),
    .cw        (cw),
    .step_en   (step_en)
  );

  bsc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (step_en && cw.wr),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  bsc_alu #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_alu (
    .clk    (clk),
    .rst    (rst),
    .start  (step_en && cw.alu_go),
    .op     (mode_r),
    .a      (opnd_a),
    .b      (opnd_b),
    .busy   (alu_busy),
    .result (alu_res)
  );

  always_comb begin
    sp_m1 = sp - SPW'(1);
    sp_m2 = sp - SPW'(2);

    rd_addr = (cw.rd == RD_NEXT) ? sp_m2[AW-1:0] : sp_m1[AW-1:0];

    unique case (cw.wsel)
      WR_PUSH: wr_addr = sp[AW-1:0];
      WR_TOP:  wr_addr = sp_m1[AW-1:0];
      WR_NEXT: wr_addr = sp_m2[AW-1:0];
      default: wr_addr = sp[AW-1:0];
    endcase
    wr_data = (cw.wdat == WD_RES) ? alu_res : cval;

    sp_next = sp;
    if (step_en) begin
      case (cw.sp_op)
        SP_INC:  sp_next = sp + SPW'(1);
        SP_DEC:  sp_next = sp_m1;
        default: sp_next = sp;
      endcase
    end

    unique case (cw.val)
      VAL_ZERO:  val = '0;
      VAL_CONST: val = cval;
      VAL_B:     val = opnd_b;
      VAL_TOPB:  val = (sp == '0) ? '0 : opnd_b;
      VAL_RES:   val = alu_res;
      default:   val = '0;
    endcase

    cond.empty    = (sp == '0);
    cond.lt2      = (sp < SPW'(2));
    cond.full     = (sp == SP_FULL);
    cond.divz     = (mode_r == MODE_DIV) && (opnd_b == '0);
    cond.alu_busy = alu_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      sp <= sp_next;
      if (step_en && cw.emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= mode_t'(instr.mode);
      cval   <= instr.constant_value;
    end
    if (step_en && cw.ld_a) begin
      opnd_a <= rd_data;
    end
    if (step_en && cw.ld_b) begin
      opnd_b <= rd_data;
    end
    if (step_en && cw.emit) begin
      out_value    <= val;
      out_returned <= cw.ret;
      out_err      <= cw.err;
      out_depth    <= DEPTH_OUT_W'(sp_next);
    end
  end

  assign result.valid       = out_valid;
  assign result.top_value   = out_value;
  assign result.returned    = out_returned;
  assign result.error_code  = out_err;
  assign result.stack_depth = out_depth;

  assert property (@(posedge clk) disable iff (rst) sp <= SP_FULL)
    else $error("stack pointer beyond stack depth");

  assert property (@(posedge clk) disable iff (rst) instr.ready |-> !alu_busy)
    else $error("instruction taken while arithmetic unit busy");

  assert property (@(posedge clk) disable iff (rst)
    (step_en && cw.emit && cw.err != ERR_OK) |=> (sp == $past(sp)))
    else $error("failed instruction changed stack depth");

  assert property (@(posedge clk) disable iff (rst)
    (step_en && cw.wr && cw.wsel == WR_PUSH) |-> (sp != SP_FULL))
    else $error("push written into full stack");

endmodule

@@ tb/sv/bsc_result_checker.sv @@
// Result checker for the bytecode stack calculator: predicts every result beat and compares it.
module bsc_result_checker import bsc_pkg::*; #(
  parameter int unsigned STACK_DEPTH   = DEF_STACK_DEPTH,
  parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic clk,
  input  logic rst,
  bsc_in_if    instr,
  bsc_out_if   result,
  output int   fail_count,
  output int   outstanding,
  output int   model_depth
);

  typedef struct {
    logic signed [WORD_W-1:0] top_value;
    logic                     returned;
    err_t                     error_code;
    logic [DEPTH_OUT_W-1:0]   stack_depth;
  } outcome_t;

  logic signed [WORD_W-1:0] operand_stack [STACK_DEPTH];
  int                       depth;
  int                       errors;
  outcome_t                 awaited [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
    model_depth = 0;
    depth       = 0;
    errors      = 0;
  end

  function automatic logic signed [WORD_W-1:0] clamp_word(longint v);
    logic signed [WORD_W-1:0] w;
    if (v > longint'(32'sh7FFF_FFFF)) begin
      w = WORD_MAX;
    end else if (v < -longint'(64'h8000_0000)) begin
      w = WORD_MIN;
    end else begin
      w = v[WORD_W-1:0];
    end
    return w;
  endfunction

  function automatic outcome_t execute_instr(logic [MODE_W-1:0] op,
                                             logic signed [WORD_W-1:0] k);
    outcome_t                 o;
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
    longint                   wide;
    o.top_value  = '0;
    o.returned   = 1'b0;
    o.error_code = ERR_OK;
    wide         = 0;
    case (op)
      MODE_CONST: begin
        if (depth >= STACK_DEPTH) begin
          o.error_code = ERR_OVER;
        end else begin
          operand_stack[depth] = k;
          depth++;
        end
      end
      MODE_NEG: begin
        if (depth < 1) begin
          o.error_code = ERR_UNDER;
        end else begin
          operand_stack[depth-1] = clamp_word(-longint'(operand_stack[depth-1]));
        end
      end
      MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
        if (depth < 2) begin
          o.error_code = ERR_UNDER;
        end else begin
          b = operand_stack[depth-1];
          a = operand_stack[depth-2];
          case (op)
            MODE_ADD: wide = longint'(a) + longint'(b);
            MODE_SUB: wide = longint'(a) - longint'(b);
            MODE_MUL: wide = (longint'(a) * longint'(b)) >>> FRACTION_BITS;
            default: begin
              if (b == 0) begin
                o.error_code = ERR_DIV0;
              end else begin
                wide = (longint'(a) * (longint'(1) << FRACTION_BITS)) / longint'(b);
              end
            end
          endcase
          if (o.error_code == ERR_OK) begin
            operand_stack[depth-2] = clamp_word(wide);
            depth--;
          end
        end
      end
      MODE_RET: begin
        o.returned = 1'b1;
        if (depth < 1) begin
          o.error_code = ERR_UNDER;
        end else begin
          o.top_value = operand_stack[depth-1];
          depth--;
        end
      end
      default: ;
    endcase
    if (op != MODE_RET) begin
      o.top_value = (depth == 0) ? '0 : operand_stack[depth-1];
    end
    o.stack_depth = depth[DEPTH_OUT_W-1:0];
    return o;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      depth = 0;
      awaited.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (awaited.size() == 0) begin
          $error("result beat with no instruction outstanding: top_value %0d",
                 result.top_value);
          errors++;
        end else begin
          want = awaited.pop_front();
          if (result.top_value !== want.top_value) begin
            $error("top_value: expected %0d, got %0d", want.top_value, result.top_value);
            errors++;
          end
          if (result.returned !== want.returned) begin
            $error("returned: expected %0d, got %0d", want.returned, result.returned);
            errors++;
          end
          if (result.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, result.error_code);
            errors++;
          end
          if (result.stack_depth !== want.stack_depth) begin
            $error("stack_depth: expected %0d, got %0d", want.stack_depth,
                   result.stack_depth);
            errors++;
          end
        end
      end
      if (instr.valid && instr.ready) begin
        awaited.push_back(execute_instr(instr.mode, instr.constant_value));
      end
    end
    fail_count  <= errors;
    outstanding <= awaited.size();
    model_depth <= depth;
  end

endmodule

@@ tb/sv/tb_bytecode_stack_calculator.sv @@
// Testbench top for the bytecode stack calculator: clock, reset, instruction stimulus, verdict.
module tb_bytecode_stack_calculator;
  import bsc_pkg::*;

  localparam int                unsigned STACK_FULL = DEF_STACK_DEPTH;
  localparam int                RANDOM_ITEMS        = 610;
  localparam int                LIMIT_CYCLES        = 1000000;
  localparam logic [MODE_W-1:0] MODE_UNUSED         = 3'd7;

  logic clk;
  logic rst;
  int   fails;
  int   outstanding;
  int   depth_seen;
  int   depth_guess;
  int   cycles;
  bit   no_gaps;

  bsc_in_if  instr ();
  bsc_out_if result ();

  bytecode_stack_calculator u_top (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr),
    .result (result)
  );

  bsc_result_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .instr       (instr),
    .result      (result),
    .fail_count  (fails),
    .outstanding (outstanding),
    .model_depth (depth_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    if (r < 55) return $urandom_range(0, 131071) - 65536;
    if (r < 65) begin
      case ($urandom_range(0, 6))
        0:       return WORD_MAX;
        1:       return WORD_MIN;
        2:       return '0;
        3:       return 32'h0001_0000;
        4:       return 32'hFFFF_0000;
        5:       return 32'h0000_0001;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [MODE_W-1:0] pick_op(int push_pct);
    logic [MODE_W-1:0] op;
    int                r;
    r = $urandom_range(0, 99);
    if (depth_guess < 2) begin
      if (depth_guess == 1 && r < 20) begin
        op = (r < 10) ? MODE_NEG : MODE_RET;
      end else begin
        op = MODE_CONST;
      end
    end else if (r < push_pct) begin
      op = MODE_CONST;
    end else begin
      case ($urandom_range(0, 9))
        0:       op = MODE_NEG;
        1, 2:    op = MODE_ADD;
        3, 4:    op = MODE_SUB;
        5, 6:    op = MODE_MUL;
        7, 8:    op = MODE_DIV;
        default: op = MODE_RET;
      endcase
    end
    return op;
  endfunction

  task automatic send_instr(input logic [MODE_W-1:0] op, input logic [WORD_W-1:0] k);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      instr.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr.valid          <= 1'b1;
    instr.mode           <= op;
    instr.constant_value <= k;
    do @(posedge clk); while (!instr.ready);
    case (op)
      MODE_CONST: begin
        if (depth_guess < STACK_FULL) depth_guess++;
      end
      MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
        if (depth_guess >= 2) depth_guess--;
      end
      MODE_RET: begin
        if (depth_guess >= 1) depth_guess--;
      end
      default: ;
    endcase
  endtask

  task automatic drain_results();
    instr.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    depth_guess = depth_seen;
  endtask

  // result side: random stalls, with a long hold-off now and then to back up the block
  initial begin : result_side
    int stall_left;
    int open_left;
    int beats;
    int hold_mark;
    logic rdy;
    stall_left = 0;
    open_left  = 0;
    beats      = 0;
    hold_mark  = 150;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result.valid && result.ready) beats++;
      if (stall_left == 0 && open_left == 0) begin
        if (beats >= hold_mark) begin
          stall_left = 400;
          open_left  = 1;
          hold_mark += 250;
        end else begin
          stall_left = pick_gap();
          open_left  = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        open_left--;
        rdy = 1'b1;
      end
      result.ready <= rdy;
    end
  end

  initial begin : run_limit
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int                sent;
    int                len;
    int                push_pct;
    bit                filled;
    logic [MODE_W-1:0] op;
    depth_guess = 0;
    no_gaps     = 1'b0;
    rst                  <= 1'b1;
    instr.valid          <= 1'b0;
    instr.mode           <= MODE_CONST;
    instr.constant_value <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_instr(MODE_RET, '0);
    send_instr(MODE_NEG, '0);
    send_instr(MODE_UNUSED, 32'hFFFF_FFFF);
    send_instr(MODE_CONST, WORD_MAX);
    send_instr(MODE_DIV, '0);
    send_instr(MODE_CONST, 32'h0000_0001);
    send_instr(MODE_ADD, '0);
    send_instr(MODE_CONST, WORD_MIN);
    send_instr(MODE_NEG, '0);
    send_instr(MODE_MUL, '0);
    send_instr(MODE_CONST, WORD_MIN);
    send_instr(MODE_SUB, '0);
    send_instr(MODE_CONST, WORD_MIN);
    send_instr(MODE_CONST, 32'h0000_0001);
    send_instr(MODE_SUB, '0);
    send_instr(MODE_CONST, '0);
    send_instr(MODE_DIV, '0);
    send_instr(MODE_RET, '0);
    send_instr(MODE_CONST, 32'hFFFF_8000);
    send_instr(MODE_DIV, '0);
    send_instr(MODE_CONST, 32'hFFFF_FFFF);
    send_instr(MODE_MUL, '0);
    send_instr(MODE_CONST, 32'h0003_0000);
    send_instr(MODE_DIV, '0);
    send_instr(MODE_RET, '0);
    drain_results();

    sent   = 0;
    filled = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      no_gaps  = ($urandom_range(0, 3) == 0);
      push_pct = $urandom_range(25, 60);
      if (!filled && sent >= 150) begin
        drain_results();
        while (depth_guess < STACK_FULL) begin
          send_instr(MODE_CONST, rand_word());
          sent++;
        end
        repeat (3) begin
          send_instr(MODE_CONST, rand_word());
          sent++;
        end
        filled = 1'b1;
      end
      len = $urandom_range(4, 30);
      repeat (len) begin
        if ($urandom_range(0, 99) < 85) begin
          op = pick_op(push_pct);
        end else begin
          op = MODE_W'($urandom_range(0, 7));
        end
        send_instr(op, rand_word());
        sent++;
      end
      if ($urandom_range(0, 5) == 0) drain_results();
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
